// File: rtl/kis_pkg.sv
package kis_pkg;

    localparam int MAX_FRAMES   = 256;
    localparam int MAX_SAMPLES  = 4096;
    localparam int TIME_FRAC    = 16;

    localparam int TIME_W    = 32;
    localparam int FRAME_AW  = $clog2(MAX_FRAMES);
    localparam int FCNT_W    = FRAME_AW + 1;
    localparam int SAMPLE_AW = $clog2(MAX_SAMPLES);
    localparam int SCNT_W    = SAMPLE_AW + 1;
    localparam int SPS_W     = 8;
    localparam int CFG_W     = FCNT_W;

    // shared divider: dividend holds |rel| * sample_count
    localparam int DIV_NW = TIME_W + SCNT_W + 3;
    localparam int DIV_DW = TIME_W;
    localparam int DIV_CW = $clog2(DIV_NW);

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic       CFG_FRAME_COUNT = 1'b0;
    localparam logic       CFG_SPS         = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FEW     = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_B_CNT,
        ST_B_DIVS,
        ST_B_DIVW,
        ST_B_SMP,
        ST_B_RD,
        ST_B_CMP,
        ST_B_WR,
        ST_Q_CHK,
        ST_Q_MOD,
        ST_Q_MUL,
        ST_Q_IDX,
        ST_Q_TRD
    } t_state;

endpackage

// File: rtl/kis_ram.sv
module kis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/kis_div.sv
module kis_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kis_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [kis_pkg::DIV_NW-1:0] o_quot,
    output logic [kis_pkg::DIV_DW-1:0] o_rem
);

    logic                       r_run;
    logic                       r_done;
    logic [kis_pkg::DIV_CW-1:0] r_cnt;
    logic [kis_pkg::DIV_NW-1:0] r_quo;
    logic [kis_pkg::DIV_DW-1:0] r_rem;
    logic [kis_pkg::DIV_DW-1:0] r_dvs;

    logic [kis_pkg::DIV_DW:0]   w_sh;
    logic [kis_pkg::DIV_DW:0]   w_diff;
    logic                       w_ge;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign w_sh   = {r_rem, r_quo[kis_pkg::DIV_NW-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == kis_pkg::DIV_CW'(kis_pkg::DIV_NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[kis_pkg::DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[kis_pkg::DIV_DW-1:0] : w_sh[kis_pkg::DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: rtl/keyframe_index_sampler.sv
// Keyframe index sampler.
// Keyframe times (signed Q16.16 s) are written one at a time with start high,
// i_op write, the slot and the time. With two or more frames, writing slot
// frame_count-1 (frame_count capped at 256) rebuilds the sample table; a
// query (i_op query, time, loop flag) returns one result on
// o_kf_index/o_status, flagged by a single-cycle o_valid strobe. An item is
// transferred when start is high and busy is low. A write that does not
// rebuild leaves busy low. A query with fewer than two frames answers in the
// next cycle, busy stays low. A clamped or zero-length query answers without
// the divider; a table query uses the shared 48-step bit-serial divider for
// the index, in loop mode after a pass for the wrap. A rebuild uses it for
// the sample spacing (not with one table entry or none), then per entry
// probes keyframes in a downward search through the single keyframe RAM port.
// One item at a time; busy stays high until any result of the item is given.
// The receiver cannot stall; o_valid is not held.
// Reset clears frame_count and the sample count and sets samples_per_second
// to 60; keyframe and table memories are not cleared (no clearing pass).
// Configuration (i_cfg_we/i_cfg_index/i_cfg_data) is to be written only while
// idle; the block does not enforce this.
module keyframe_index_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [7:0]                    i_keyframe_slot,
    input  logic signed [31:0]            i_time_value,
    input  logic                          i_loop_mode,
    output logic                          o_valid,
    output logic [7:0]                    o_kf_index,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [kis_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW  = kis_pkg::FRAME_AW;
    localparam int SAW = kis_pkg::SAMPLE_AW;
    localparam int SCW = kis_pkg::SCNT_W;
    localparam int FW  = kis_pkg::FCNT_W;

    kis_pkg::t_state r_state, n_state;

    logic [FW-1:0]                 r_frames;
    logic [kis_pkg::SPS_W-1:0]     r_sps;
    logic [SCW-1:0]                r_scount, n_scount;
    logic                          r_valid, n_valid;
    logic [7:0]                    r_oidx, n_oidx;
    logic [1:0]                    r_ostat, n_ostat;

    logic                          r_is_query, n_is_query;
    logic                          r_loop, n_loop;
    logic signed [31:0]            r_tv, n_tv;
    logic signed [31:0]            r_start, n_start;
    logic signed [31:0]            r_end, n_end;
    logic signed [31:0]            r_pen, n_pen;
    logic signed [32:0]            r_dur, n_dur;
    logic signed [32:0]            r_rel, n_rel;
    logic [31:0]                   r_absd, n_absd;
    logic [31:0]                   r_rel2, n_rel2;
    logic [31:0]                   r_q, n_q;
    logic [SAW-1:0]                r_r, n_r;
    logic [SAW-1:0]                r_d, n_d;
    logic [31:0]                   r_qacc, n_qacc;
    logic [SAW-1:0]                r_racc, n_racc;
    logic signed [33:0]            r_t, n_t;
    logic [AW-1:0]                 r_j, n_j;
    logic [SAW-1:0]                r_i, n_i;
    logic [7:0]                    r_entry, n_entry;

    logic [FW-1:0]                 w_n;
    logic [AW-1:0]                 w_nm1, w_nm2;
    logic                          w_accept;

    logic                          kt_we;
    logic [AW-1:0]                 kt_raddr;
    logic [31:0]                   kt_rdata;
    logic                          tb_we;
    logic [SAW-1:0]                tb_raddr;
    logic [7:0]                    tb_rdata;

    kis_pkg::t_div_req             div_req;
    logic                          div_done;
    logic [kis_pkg::DIV_NW-1:0]    div_quot;
    logic [kis_pkg::DIV_DW-1:0]    div_rem;

    logic [39:0]                   w_cprod;
    logic [23:0]                   w_csh;
    logic [44:0]                   w_qprod;
    logic [SAW:0]                  w_rsum;
    logic [31:0]                   w_relabs;

    assign w_n      = (r_frames > FW'(kis_pkg::MAX_FRAMES)) ? FW'(kis_pkg::MAX_FRAMES) : r_frames;
    assign w_nm1    = AW'(w_n - FW'(1));
    assign w_nm2    = AW'(w_n - FW'(2));
    assign w_accept = start && (r_state == kis_pkg::ST_IDLE);

    assign w_cprod  = {8'b0, r_dur[31:0]} * {32'b0, r_sps};
    assign w_csh    = w_cprod[39:kis_pkg::TIME_FRAC];
    assign w_qprod  = {13'b0, r_rel2} * {32'b0, r_scount};
    assign w_rsum   = {1'b0, r_racc} + {1'b0, r_r};
    assign w_relabs = r_rel[32] ? 32'(-r_rel) : r_rel[31:0];

    kis_ram #(.WIDTH(32), .DEPTH(kis_pkg::MAX_FRAMES)) u_kt_ram (
        .i_clk   (i_clk),
        .i_we    (kt_we),
        .i_waddr (AW'(i_keyframe_slot)),
        .i_wdata (i_time_value),
        .i_raddr (kt_raddr),
        .o_rdata (kt_rdata)
    );

    kis_ram #(.WIDTH(8), .DEPTH(kis_pkg::MAX_SAMPLES)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (r_i),
        .i_wdata (r_entry),
        .i_raddr (tb_raddr),
        .o_rdata (tb_rdata)
    );

    kis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kis_pkg::ST_IDLE;
            r_frames <= '0;
            r_sps    <= kis_pkg::SPS_W'(60);
            r_scount <= '0;
            r_valid  <= 1'b0;
            r_oidx   <= '0;
            r_ostat  <= kis_pkg::STAT_OK;
        end else begin
            r_state  <= n_state;
            r_scount <= n_scount;
            r_valid  <= n_valid;
            r_oidx   <= n_oidx;
            r_ostat  <= n_ostat;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kis_pkg::CFG_FRAME_COUNT: r_frames <= i_cfg_data;
                    kis_pkg::CFG_SPS:         r_sps    <= i_cfg_data[kis_pkg::SPS_W-1:0];
                    default:                  r_frames <= r_frames;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_query <= n_is_query;
        r_loop     <= n_loop;
        r_tv       <= n_tv;
        r_start    <= n_start;
        r_end      <= n_end;
        r_pen      <= n_pen;
        r_dur      <= n_dur;
        r_rel      <= n_rel;
        r_absd     <= n_absd;
        r_rel2     <= n_rel2;
        r_q        <= n_q;
        r_r        <= n_r;
        r_d        <= n_d;
        r_qacc     <= n_qacc;
        r_racc     <= n_racc;
        r_t        <= n_t;
        r_j        <= n_j;
        r_i        <= n_i;
        r_entry    <= n_entry;
    end

    always_comb begin
        n_state    = r_state;
        n_scount   = r_scount;
        n_valid    = 1'b0;
        n_oidx     = r_oidx;
        n_ostat    = r_ostat;
        n_is_query = r_is_query;
        n_loop     = r_loop;
        n_tv       = r_tv;
        n_start    = r_start;
        n_end      = r_end;
        n_pen      = r_pen;
        n_dur      = r_dur;
        n_rel      = r_rel;
        n_absd     = r_absd;
        n_rel2     = r_rel2;
        n_q        = r_q;
        n_r        = r_r;
        n_d        = r_d;
        n_qacc     = r_qacc;
        n_racc     = r_racc;
        n_t        = r_t;
        n_j        = r_j;
        n_i        = r_i;
        n_entry    = r_entry;

        kt_we      = 1'b0;
        kt_raddr   = '0;
        tb_we      = 1'b0;
        tb_raddr   = '0;
        div_req    = '0;

        unique case (r_state)
            kis_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_is_query = (i_op == kis_pkg::OP_QUERY);
                    n_loop     = i_loop_mode;
                    n_tv       = i_time_value;
                    if (i_op == kis_pkg::OP_WRITE) begin
                        kt_we = 1'b1;
                        if (w_n >= FW'(2) && {1'b0, i_keyframe_slot} == FW'(w_n - FW'(1))) begin
                            n_state = kis_pkg::ST_F0;
                        end
                    end else if (w_n < FW'(2)) begin
                        n_valid = 1'b1;
                        n_oidx  = '0;
                        n_ostat = kis_pkg::STAT_FEW;
                    end else begin
                        n_state = kis_pkg::ST_F0;
                    end
                end
            end
            // fetch first, last and second-to-last keyframe
            kis_pkg::ST_F0: begin
                kt_raddr = '0;
                n_state  = kis_pkg::ST_F1;
            end
            kis_pkg::ST_F1: begin
                kt_raddr = w_nm1;
                n_start  = kt_rdata;
                n_state  = kis_pkg::ST_F2;
            end
            kis_pkg::ST_F2: begin
                kt_raddr = w_nm2;
                n_end    = kt_rdata;
                n_state  = kis_pkg::ST_F3;
            end
            kis_pkg::ST_F3: begin
                n_pen   = kt_rdata;
                n_dur   = {r_end[31], r_end} - {r_start[31], r_start};
                n_rel   = {r_tv[31], r_tv} - {r_start[31], r_start};
                n_state = r_is_query ? kis_pkg::ST_Q_CHK : kis_pkg::ST_B_CNT;
            end
            kis_pkg::ST_B_CNT: begin
                if (r_dur[32] || r_dur == '0) begin
                    n_scount = '0;
                end else if (w_csh > 24'(kis_pkg::MAX_SAMPLES)) begin
                    n_scount = SCW'(kis_pkg::MAX_SAMPLES);
                end else begin
                    n_scount = w_csh[SCW-1:0];
                end
                n_state = kis_pkg::ST_B_DIVS;
            end
            kis_pkg::ST_B_DIVS: begin
                n_i    = '0;
                n_qacc = '0;
                n_racc = '0;
                n_d    = SAW'(r_scount - SCW'(1));
                if (r_scount == '0) begin
                    n_state = kis_pkg::ST_IDLE;
                end else if (r_scount == SCW'(1)) begin
                    n_q     = '0;
                    n_r     = '0;
                    n_d     = SAW'(1);
                    n_state = kis_pkg::ST_B_SMP;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = kis_pkg::DIV_NW'(r_dur[31:0]);
                    div_req.divisor  = kis_pkg::DIV_DW'(SAW'(r_scount - SCW'(1)));
                    n_state          = kis_pkg::ST_B_DIVW;
                end
            end
            kis_pkg::ST_B_DIVW: begin
                if (div_done) begin
                    n_q     = div_quot[31:0];
                    n_r     = div_rem[SAW-1:0];
                    n_state = kis_pkg::ST_B_SMP;
                end
            end
            kis_pkg::ST_B_SMP: begin
                n_t     = {{2{r_start[31]}}, r_start} + {2'b0, r_qacc};
                n_j     = w_nm1;
                n_state = kis_pkg::ST_B_RD;
            end
            kis_pkg::ST_B_RD: begin
                kt_raddr = r_j;
                n_state  = kis_pkg::ST_B_CMP;
            end
            kis_pkg::ST_B_CMP: begin
                // downward search: first keyframe at or before the tick
                if (r_t >= $signed({{2{kt_rdata[31]}}, kt_rdata})) begin
                    n_entry = 8'((r_j >= w_nm2) ? w_nm2 : r_j);
                    n_state = kis_pkg::ST_B_WR;
                end else if (r_j == '0) begin
                    n_entry = '0;
                    n_state = kis_pkg::ST_B_WR;
                end else begin
                    n_j     = r_j - AW'(1);
                    n_state = kis_pkg::ST_B_RD;
                end
            end
            kis_pkg::ST_B_WR: begin
                tb_we = 1'b1;
                if (w_rsum >= {1'b0, r_d}) begin
                    n_racc = SAW'(w_rsum - {1'b0, r_d});
                    n_qacc = r_qacc + r_q + 32'd1;
                end else begin
                    n_racc = w_rsum[SAW-1:0];
                    n_qacc = r_qacc + r_q;
                end
                if ({1'b0, r_i} == SCW'(r_scount - SCW'(1))) begin
                    n_state = kis_pkg::ST_IDLE;
                end else begin
                    n_i     = r_i + SAW'(1);
                    n_state = kis_pkg::ST_B_SMP;
                end
            end
            kis_pkg::ST_Q_CHK: begin
                if (r_loop) begin
                    n_absd = r_dur[32] ? 32'(-r_dur) : r_dur[31:0];
                    if (r_dur == '0) begin
                        n_valid = 1'b1;
                        n_oidx  = '0;
                        n_ostat = kis_pkg::STAT_OUTSIDE;
                        n_state = kis_pkg::ST_IDLE;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = kis_pkg::DIV_NW'(w_relabs);
                        div_req.divisor  = r_dur[32] ? 32'(-r_dur) : r_dur[31:0];
                        n_state          = kis_pkg::ST_Q_MOD;
                    end
                end else if (r_tv <= r_start) begin
                    n_valid = 1'b1;
                    n_oidx  = '0;
                    n_ostat = kis_pkg::STAT_OK;
                    n_state = kis_pkg::ST_IDLE;
                end else if (r_tv >= r_pen) begin
                    n_valid = 1'b1;
                    n_oidx  = 8'(w_nm2);
                    n_ostat = kis_pkg::STAT_OK;
                    n_state = kis_pkg::ST_IDLE;
                end else if (r_dur[32] || r_dur == '0) begin
                    n_valid = 1'b1;
                    n_oidx  = '0;
                    n_ostat = kis_pkg::STAT_OUTSIDE;
                    n_state = kis_pkg::ST_IDLE;
                end else begin
                    n_rel2  = r_rel[31:0];
                    n_absd  = r_dur[31:0];
                    n_state = kis_pkg::ST_Q_MUL;
                end
            end
            kis_pkg::ST_Q_MOD: begin
                if (div_done) begin
                    // truncating remainder, then fold negatives into [0, dur)
                    if (r_rel[32] && div_rem != '0) begin
                        n_rel2 = r_absd - div_rem;
                    end else begin
                        n_rel2 = div_rem;
                    end
                    n_state = kis_pkg::ST_Q_MUL;
                end
            end
            kis_pkg::ST_Q_MUL: begin
                div_req.start    = 1'b1;
                div_req.dividend = kis_pkg::DIV_NW'(w_qprod);
                div_req.divisor  = r_absd;
                n_state          = kis_pkg::ST_Q_IDX;
            end
            kis_pkg::ST_Q_IDX: begin
                if (div_done) begin
                    if (div_quot >= kis_pkg::DIV_NW'(r_scount)) begin
                        n_valid = 1'b1;
                        n_oidx  = '0;
                        n_ostat = kis_pkg::STAT_OUTSIDE;
                        n_state = kis_pkg::ST_IDLE;
                    end else begin
                        tb_raddr = div_quot[SAW-1:0];
                        n_state  = kis_pkg::ST_Q_TRD;
                    end
                end
            end
            kis_pkg::ST_Q_TRD: begin
                n_valid = 1'b1;
                n_oidx  = tb_rdata;
                n_ostat = kis_pkg::STAT_OK;
                n_state = kis_pkg::ST_IDLE;
            end
            default: begin
                n_state = kis_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != kis_pkg::ST_IDLE);
    assign o_valid       = r_valid;
    assign o_kf_index    = r_oidx;
    assign o_status      = r_ostat;

endmodule

// File: rtl/kis_checker.sv
module kis_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_op,
    input logic       o_valid,
    input logic [7:0] o_kf_index,
    input logic [1:0] o_status
);

    // a result closes its item: the block is idle when it shows
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == kis_pkg::STAT_OK || o_status == kis_pkg::STAT_FEW ||
                     o_status == kis_pkg::STAT_OUTSIDE))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != kis_pkg::STAT_OK) |-> (o_kf_index == 8'd0))
        else $error("failed query with nonzero index");

    a_query_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == kis_pkg::OP_QUERY) |=> (busy || o_valid))
        else $error("query transfer dropped");

endmodule

bind keyframe_index_sampler kis_checker u_kis_checker (.*);

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kis_pkg::*;

    typedef struct {
        logic              op;
        logic [7:0]        slot;
        logic signed [31:0] tv;
        logic              loop;
    } kf_item_t;

    typedef struct {
        logic [7:0] idx;
        logic [1:0] stat;
    } lookup_res_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               cfg_sel;
        logic [CFG_W-1:0]   cfg_val;
        kf_item_t           item;
        bit                 typed;
        lookup_res_t        res;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_op = OP_WRITE;
    logic [7:0]         i_keyframe_slot = '0;
    logic signed [31:0] i_time_value = '0;
    logic               i_loop_mode = 1'b0;
    logic               o_valid;
    logic [7:0]         o_kf_index;
    logic [1:0]         o_status;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CFG_FRAME_COUNT;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    keyframe_index_sampler i_dut (.*);

    always #6 i_clk = ~i_clk;

    // shadow of the block's state
    logic signed [31:0] kf_time [MAX_FRAMES];
    bit                 kf_written [MAX_FRAMES];
    logic [7:0]         smp_tab [MAX_SAMPLES];
    int unsigned        smp_cnt = 0;
    int unsigned        fc_reg = 0;
    int unsigned        sps_reg = 60;

    lookup_res_t expected_q [$];
    stim_row_t   rows [$];
    int          errors = 0;
    int          items_sent = 0;
    bit          quiet = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int unsigned frames_eff();
        return fc_reg > MAX_FRAMES ? MAX_FRAMES : fc_reg;
    endfunction

    function automatic void rebuild_table();
        int unsigned n;
        longint st, du, t, cnt;
        int j, pick;
        n = frames_eff();
        if (n < 2)
            return;
        st = longint'(kf_time[0]);
        du = longint'(kf_time[n-1]) - st;
        if (du <= 0)
            cnt = 0;
        else begin
            cnt = (du * sps_reg) >>> TIME_FRAC;
            if (cnt > MAX_SAMPLES)
                cnt = MAX_SAMPLES;
        end
        smp_cnt = cnt;
        for (int i = 0; i < cnt; i++) begin
            t = st;
            if (cnt > 1)
                t += (longint'(i) * du) / (cnt - 1);
            // downward search for the last keyframe at or before the tick
            pick = 0;
            j = n;
            while (j > 0) begin
                j--;
                if (t >= longint'(kf_time[j])) begin
                    pick = (j >= n - 2) ? n - 2 : j;
                    break;
                end
            end
            smp_tab[i] = pick;
        end
    endfunction

    // returns 1 when the item yields a result
    function automatic bit predict_lookup(input kf_item_t it, output lookup_res_t r);
        int unsigned n;
        longint st, du, rel, ix;
        n = frames_eff();
        r.idx = '0;
        r.stat = STAT_OK;
        if (it.op == OP_WRITE) begin
            kf_time[it.slot] = it.tv;
            kf_written[it.slot] = 1;
            if (n >= 1 && it.slot == n - 1)
                rebuild_table();
            return 0;
        end
        if (n < 2) begin
            r.stat = STAT_FEW;
            return 1;
        end
        st = longint'(kf_time[0]);
        du = longint'(kf_time[n-1]) - st;
        rel = longint'(it.tv) - st;
        if (it.loop) begin
            if (du < 0)
                du = -du;
            if (du == 0)
                rel = 0;
            else begin
                rel = rel % du;
                if (rel < 0)
                    rel += du;
            end
        end else begin
            if (longint'(it.tv) <= st)
                return 1;
            if (longint'(it.tv) >= longint'(kf_time[n-2])) begin
                r.idx = n - 2;
                return 1;
            end
        end
        if (du <= 0 || rel < 0) begin
            r.stat = STAT_OUTSIDE;
            return 1;
        end
        ix = (rel * smp_cnt) / du;
        if (ix >= smp_cnt || ix >= MAX_SAMPLES) begin
            r.stat = STAT_OUTSIDE;
            return 1;
        end
        r.idx = smp_tab[ix];
        return 1;
    endfunction

    task automatic send_item(input kf_item_t it, input bit typed, input lookup_res_t tres);
        int gap;
        lookup_res_t r;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_op            <= it.op;
        i_keyframe_slot <= it.slot;
        i_time_value    <= it.tv;
        i_loop_mode     <= it.loop;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        // transfer taken at this edge
        if (predict_lookup(it, r)) begin
            if (typed)
                expected_q.push_back(tres);
            else
                expected_q.push_back(r);
        end
        items_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic sel, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == CFG_FRAME_COUNT)
            fc_reg = val & 9'h1FF;
        else
            sps_reg = val & 8'hFF;
        @(posedge i_clk);
    endtask

    function automatic void add_item(input logic op, input int slot, input int tv,
                                      input logic loop, input bit typed = 0,
                                      input int idx = 0, input logic [1:0] stat = STAT_OK);
        stim_row_t r;
        r.kind = ROW_ITEM;
        r.item = '{op, slot[7:0], tv, loop};
        r.typed = typed;
        r.res = '{idx[7:0], stat};
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic sel, input int val);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.cfg_sel = sel;
        r.cfg_val = CFG_W'(val);
        r.typed = 0;
        rows.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        lookup_res_t e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0)
                report("result with nothing expected");
            else begin
                e = expected_q.pop_front();
                if (o_kf_index !== e.idx)
                    report($sformatf("key index %0d, expected %0d", o_kf_index, e.idx));
                if (o_status !== e.stat)
                    report($sformatf("status %0d, expected %0d", o_status, e.stat));
            end
        end
    end

    initial begin
        #1_200_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        kf_item_t it;
        lookup_res_t none;
        int unsigned n, spsv, fcv, step, phase_len;
        longint st, t, du;
        int pick;

        none = '{8'd0, STAT_OK};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        add_item(OP_QUERY, 0, 0, 0, 1, 0, STAT_FEW);
        add_cfg(CFG_FRAME_COUNT, 1);
        add_item(OP_QUERY, 0, 32'h7FFFFFFF, 1, 1, 0, STAT_FEW);
        add_cfg(CFG_FRAME_COUNT, 3);
        add_cfg(CFG_SPS, 240);
        add_item(OP_WRITE, 0, 0, 0);
        add_item(OP_WRITE, 1, 32'h8000, 0);
        add_item(OP_WRITE, 2, 32'h10000, 0);
        add_item(OP_QUERY, 0, 32'h80000000, 0, 1, 0, STAT_OK);
        add_item(OP_QUERY, 0, 32'h7FFFFFFF, 0, 1, 1, STAT_OK);
        add_item(OP_QUERY, 0, 32'h7FFFFFFF, 1);
        add_item(OP_QUERY, 0, 32'h80000000, 1);
        add_item(OP_QUERY, 0, 32'h4000, 0);
        add_item(OP_QUERY, 0, 32'h10000, 1);
        add_item(OP_WRITE, 255, 32'hFFFFFFFF, 1);
        add_cfg(CFG_SPS, 1);
        add_item(OP_WRITE, 2, 32'h10000, 0);
        add_item(OP_QUERY, 0, 32'h100, 0);
        // zero-length track: no table at all
        add_cfg(CFG_FRAME_COUNT, 2);
        add_item(OP_WRITE, 0, 5, 0);
        add_item(OP_WRITE, 1, 5, 0);
        add_item(OP_QUERY, 0, 3, 0, 1, 0, STAT_OK);
        add_item(OP_QUERY, 0, 5, 0, 1, 0, STAT_OK);
        add_item(OP_QUERY, 0, 100, 1, 1, 0, STAT_OUTSIDE);
        // track running backwards
        add_item(OP_WRITE, 1, 1, 0);
        add_item(OP_QUERY, 0, 3, 1);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                wait_idle();
                write_cfg(rows[k].cfg_sel, rows[k].cfg_val);
            end else
                send_item(rows[k].item, rows[k].typed, rows[k].res);
        end

        // random part, one track per phase
        for (int ph = 0; items_sent < 760; ph++) begin
            wait_idle();
            pick = $urandom_range(0, 15);
            if (ph == 1)
                fcv = 511;
            else if (pick == 0)
                fcv = $urandom_range(0, 1);
            else if (pick == 1)
                fcv = $urandom_range(257, 510);
            else if (pick < 4)
                fcv = $urandom_range(9, 40);
            else
                fcv = $urandom_range(2, 8);
            case ($urandom_range(0, 5))
                0:       spsv = 1;
                1:       spsv = 240;
                default: spsv = $urandom_range(1, 240);
            endcase
            write_cfg(CFG_FRAME_COUNT, fcv);
            write_cfg(CFG_SPS, spsv);
            quiet = ($urandom_range(0, 3) == 0);
            n = frames_eff();
            // well-formed ascending track, written slot by slot
            st = $urandom_range(0, 3) == 0 ? longint'($signed($urandom))
                                           : longint'($urandom_range(0, 32'h40000)) - 32'h20000;
            if (n > 40)
                step = 64;
            else if (n == 2 && $urandom_range(0, 4) == 0)
                step = 32'h7FFFFFFF;
            else if (n > 8)
                step = 32'h2000;
            else
                step = 32'h8000;
            t = st;
            for (int s = 0; s < (n < 2 ? 2 : n); s++) begin
                it = '{OP_WRITE, s[7:0], t[31:0], 1'($urandom)};
                send_item(it, 0, none);
                t += $urandom_range(0, step);
            end
            du = longint'(kf_time[n < 2 ? 1 : n-1]) - st;
            phase_len = $urandom_range(20, 60);
            for (int k = 0; k < phase_len; k++) begin
                pick = $urandom_range(0, 9);
                it.loop = $urandom;
                it.slot = $urandom;
                it.tv = $urandom;
                if (pick < 6) begin
                    it.op = OP_QUERY;
                    if (pick < 4)
                        it.tv = st - 32'h100 + longint'($urandom_range(0, 32'h7FFFFFFF)) %
                                ((du < 0 ? -du : du) + 32'h300);
                end else if (pick == 6 && n >= 2 && n <= 40) begin
                    it.op = OP_WRITE;
                    it.slot = n - 1;
                    if ($urandom_range(0, 1))
                        it.tv = st + $urandom_range(0, 32'h20000);
                end else if (pick < 9 && n >= 3) begin
                    it.op = OP_WRITE;
                    it.slot = $urandom_range(0, n - 2);
                    if ($urandom_range(0, 3) != 0)
                        it.tv = st + $urandom_range(0, step * n);
                end else begin
                    // slot past the track: stored only
                    it.op = OP_WRITE;
                    if (n < MAX_FRAMES)
                        it.slot = $urandom_range(n, 255);
                    else
                        it.op = OP_QUERY;
                end
                send_item(it, 0, none);
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
